FILE: design/sat_pkg.sv
`timescale 1ns / 1ps
// sat_pkg: shared types and constants for the section address translator
// no dependencies

package sat_pkg;

    localparam int ADDR_W     = 32;
    localparam int OP_W       = 2;
    localparam int ENTRY_W    = 4;
    localparam int HIT_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int GROUP_SIZE = 8;
    localparam int LOC_W      = 3;

    localparam logic [OP_W-1:0] OP_LOAD      = 2'd0;
    localparam logic [OP_W-1:0] OP_IMG2FILE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FILE2IMG  = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] virt_base;
        logic [ADDR_W-1:0] virt_length;
        logic [ADDR_W-1:0] raw_base;
        logic [ADDR_W-1:0] raw_length;
    } sect_desc_t;

endpackage

FILE: design/section_address_translate.sv
`timescale 1ns / 1ps
// section_address_translate: section table and four-stage translate pipeline
// depends on sat_pkg
// one transaction per cycle, unless m_ready held low stalls the pipeline
// stage 1 compares all entries in groups of eight, stage 2 picks the first group,
// stage 3 forms the offset, stage 4 is the output register
// reset clears valid bits and section_count; table contents stay undefined until loaded

module section_address_translate
    import sat_pkg::*;
#(
    parameter int MAX_SECTIONS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 section_count_we,
    input  logic [COUNT_W-1:0]   section_count_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_op,
    input  logic [ENTRY_W-1:0]   s_entry_index,
    input  logic [ADDR_W-1:0]    s_virt_base,
    input  logic [ADDR_W-1:0]    s_virt_length,
    input  logic [ADDR_W-1:0]    s_raw_base,
    input  logic [ADDR_W-1:0]    s_raw_length,
    input  logic [ADDR_W-1:0]    s_lookup_address,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_translated,
    output logic                 m_found,
    output logic [HIT_W-1:0]     m_hit_index
);

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int NGRP  = (MAX_SECTIONS + GROUP_SIZE - 1) / GROUP_SIZE;

    // config register
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (section_count_we) begin
            count_reg <= section_count_wdata;
        end
    end

    // handshake chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, out_ready;

    assign out_ready = !out_valid_reg || m_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready)  s1_valid_reg  <= s_valid;
            if (s2_ready)  s2_valid_reg  <= s1_valid_reg;
            if (s3_ready)  s3_valid_reg  <= s2_valid_reg;
            if (out_ready) out_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: captured transaction
    logic [OP_W-1:0]    s1_op_reg;
    logic [ENTRY_W-1:0] s1_entry_index_reg;
    sect_desc_t         s1_desc_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_op_reg                 <= s_op;
            s1_entry_index_reg        <= s_entry_index;
            s1_desc_reg.virt_base     <= s_virt_base;
            s1_desc_reg.virt_length   <= s_virt_length;
            s1_desc_reg.raw_base      <= s_raw_base;
            s1_desc_reg.raw_length    <= s_raw_length;
            s1_addr_reg               <= s_lookup_address;
        end
    end

    // section table, written as a load leaves stage 1 so order is kept
    sect_desc_t table_reg [MAX_SECTIONS];

    logic [IDX_W+ENTRY_W-1:0] wr_ext;
    logic [IDX_W-1:0]         wr_addr;
    logic                     wr_en;

    assign wr_ext  = {{IDX_W{1'b0}}, s1_entry_index_reg};
    assign wr_addr = wr_ext[IDX_W-1:0];
    assign wr_en   = s1_valid_reg && s2_ready && (s1_op_reg == OP_LOAD)
                     && (int'(wr_ext) < MAX_SECTIONS);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_reg[wr_addr] <= s1_desc_reg;
        end
    end

    logic s1_xlate;
    logic s1_img2file;

    assign s1_img2file = (s1_op_reg == OP_IMG2FILE);
    assign s1_xlate    = s1_img2file || (s1_op_reg == OP_FILE2IMG);

    // stage 1 compare: first hit inside each group of eight
    logic [NGRP-1:0]   grp_hit_next;
    logic [LOC_W-1:0]  grp_loc_next  [NGRP];
    logic [ADDR_W-1:0] grp_from_next [NGRP];
    logic [ADDR_W-1:0] grp_to_next   [NGRP];

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [GROUP_SIZE-1:0] ent_hit;
        logic [ADDR_W-1:0]     ent_from [GROUP_SIZE];
        logic [ADDR_W-1:0]     ent_to   [GROUP_SIZE];

        for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_ent
            localparam int ENT  = g * GROUP_SIZE + j;
            localparam int SLOT = (ENT < MAX_SECTIONS) ? ENT : MAX_SECTIONS - 1;
            logic [ADDR_W-1:0] len;
            logic [ADDR_W-1:0] top;

            assign ent_from[j] = s1_img2file ? table_reg[SLOT].virt_base
                                             : table_reg[SLOT].raw_base;
            assign len         = s1_img2file ? table_reg[SLOT].virt_length
                                             : table_reg[SLOT].raw_length;
            assign ent_to[j]   = s1_img2file ? table_reg[SLOT].raw_base
                                             : table_reg[SLOT].virt_base;
            assign top         = ent_from[j] + len;
            assign ent_hit[j]  = (ENT < MAX_SECTIONS) && s1_xlate
                                 && (ENT < int'(count_reg))
                                 && (ent_from[j] <= s1_addr_reg)
                                 && (top > s1_addr_reg);
        end

        always_comb begin
            grp_hit_next[g]  = 1'b0;
            grp_loc_next[g]  = '0;
            grp_from_next[g] = ent_from[0];
            grp_to_next[g]   = ent_to[0];
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (!grp_hit_next[g] && ent_hit[j]) begin
                    grp_hit_next[g]  = 1'b1;
                    grp_loc_next[g]  = LOC_W'(j);
                    grp_from_next[g] = ent_from[j];
                    grp_to_next[g]   = ent_to[j];
                end
            end
        end
    end

    // stage 2: per-group results
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [NGRP-1:0]   s2_grp_hit_reg;
    logic [LOC_W-1:0]  s2_grp_loc_reg  [NGRP];
    logic [ADDR_W-1:0] s2_grp_from_reg [NGRP];
    logic [ADDR_W-1:0] s2_grp_to_reg   [NGRP];

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_addr_reg    <= s1_addr_reg;
            s2_grp_hit_reg <= grp_hit_next;
            s2_grp_loc_reg  <= grp_loc_next;
            s2_grp_from_reg <= grp_from_next;
            s2_grp_to_reg   <= grp_to_next;
        end
    end

    // first group with a hit
    logic              win_found_next;
    logic [IDX_W-1:0]  win_idx_next;
    logic [ADDR_W-1:0] win_from_next;
    logic [ADDR_W-1:0] win_to_next;

    always_comb begin
        win_found_next = 1'b0;
        win_idx_next   = '0;
        win_from_next  = s2_grp_from_reg[0];
        win_to_next    = s2_grp_to_reg[0];
        for (int g = 0; g < NGRP; g++) begin
            if (!win_found_next && s2_grp_hit_reg[g]) begin
                win_found_next = 1'b1;
                win_idx_next   = IDX_W'(g * GROUP_SIZE + int'(s2_grp_loc_reg[g]));
                win_from_next  = s2_grp_from_reg[g];
                win_to_next    = s2_grp_to_reg[g];
            end
        end
    end

    // stage 3: winning entry
    logic [ADDR_W-1:0] s3_addr_reg;
    logic              s3_found_reg;
    logic [IDX_W-1:0]  s3_idx_reg;
    logic [ADDR_W-1:0] s3_from_reg;
    logic [ADDR_W-1:0] s3_to_reg;

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            s3_addr_reg  <= s2_addr_reg;
            s3_found_reg <= win_found_next;
            s3_idx_reg   <= win_idx_next;
            s3_from_reg  <= win_from_next;
            s3_to_reg    <= win_to_next;
        end
    end

    logic [ADDR_W-1:0]        translated_next;
    logic [IDX_W+HIT_W-1:0]   hit_ext;
    logic [HIT_W-1:0]         hit_next;

    assign translated_next = s3_found_reg ? (s3_addr_reg - s3_from_reg + s3_to_reg) : '0;
    assign hit_ext         = {{HIT_W{1'b0}}, s3_idx_reg};
    assign hit_next        = s3_found_reg ? hit_ext[HIT_W-1:0] : '0;

    // output register
    logic [ADDR_W-1:0] translated_reg;
    logic              found_reg;
    logic [HIT_W-1:0]  hit_index_reg;

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            translated_reg <= translated_next;
            found_reg      <= s3_found_reg;
            hit_index_reg  <= hit_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_translated = translated_reg;
    assign m_found      = found_reg;
    assign m_hit_index  = hit_index_reg;

endmodule
